// ===== hw/rtl/fdbb_pkg.sv =====
`default_nettype none

package fdbb_pkg;

  // Fixed field widths of the configuration, item and result ports.
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int COUNT_W   = 23;
  localparam int BOX_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Default frame size limits and register reset value.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(2048);

  // The changed-pixel count saturates here.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-cycle control shared by the scan counters and the accumulator.
  typedef struct packed {
    logic step;     // an item is accepted this cycle
    logic restart;  // a register write restarts the frame
  } fdbb_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fdbb_scan.sv =====
`default_nettype none

module fdbb_scan #(
  parameter int MAX_WIDTH  = fdbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdbb_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fdbb_pkg::fdbb_ctrl_t ctrl,
  input  wire logic [CW-1:0]      eff_width,
  input  wire logic [RW-1:0]      eff_height,
  output logic      [CW-1:0]      col,
  output logic      [RW-1:0]      row,
  output logic                    last
);
  import fdbb_pkg::*;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          row_end;

  // The column counter always stays below the width, so reaching it marks the row end.
  assign row_end = (col_r + CW'(1)) >= eff_width;
  assign last    = row_end && ((row_r + RW'(1)) >= eff_height);
  assign col     = col_r;
  assign row     = row_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctrl.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ctrl.step) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fdbb_accum.sv =====
`default_nettype none

module fdbb_accum #(
  parameter int MAX_WIDTH  = fdbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdbb_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fdbb_pkg::fdbb_ctrl_t           ctrl,
  input  wire logic                           changed,
  input  wire logic [CW-1:0]                  col,
  input  wire logic [RW-1:0]                  row,
  input  wire logic                           last,
  output logic      [fdbb_pkg::COUNT_W-1:0]   count,
  output logic      [fdbb_pkg::BOX_W-1:0]     left,
  output logic      [fdbb_pkg::BOX_W-1:0]     top,
  output logic      [fdbb_pkg::BOX_W-1:0]     right,
  output logic      [fdbb_pkg::BOX_W-1:0]     bottom
);
  import fdbb_pkg::*;

  logic [COUNT_W-1:0] count_r, count_upd;
  logic [CW-1:0]      min_col_r, min_col_upd, max_col_r, max_col_upd, col_end;
  logic [RW-1:0]      min_row_r, min_row_upd, max_row_r, max_row_upd, row_end;
  logic               show_box;

  assign col_end = col + CW'(1);
  assign row_end = row + RW'(1);

  // Statistics including the current pixel. The minimums start at all ones,
  // which lies above any position, so the first change always takes over.
  always_comb begin
    count_upd   = count_r;
    min_col_upd = min_col_r;
    min_row_upd = min_row_r;
    max_col_upd = max_col_r;
    max_row_upd = max_row_r;
    if (changed) begin
      if (count_r != COUNT_LIMIT) begin
        count_upd = count_r + COUNT_W'(1);
      end
      if (col < min_col_r) begin
        min_col_upd = col;
      end
      if (row < min_row_r) begin
        min_row_upd = row;
      end
      if (col_end > max_col_r) begin
        max_col_upd = col_end;
      end
      if (row_end > max_row_r) begin
        max_row_upd = row_end;
      end
    end
  end

  assign show_box = last && (count_upd != '0);
  assign count    = count_upd;
  assign left     = show_box ? BOX_W'(min_col_upd) : '0;
  assign top      = show_box ? BOX_W'(min_row_upd) : '0;
  assign right    = show_box ? BOX_W'(max_col_upd) : '0;
  assign bottom   = show_box ? BOX_W'(max_row_upd) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart || (ctrl.step && last)) begin
      count_r   <= '0;
      min_col_r <= '1;
      min_row_r <= '1;
      max_col_r <= '0;
      max_row_r <= '0;
    end else if (ctrl.step) begin
      count_r   <= count_upd;
      min_col_r <= min_col_upd;
      min_row_r <= min_row_upd;
      max_col_r <= max_col_upd;
      max_row_r <= max_row_upd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/frame_diff_bounding_box.sv =====
// Frame difference detector with a changed-region bounding box.
// Input channel (in_valid/in_ready): one item per pixel position, a gray pixel
// from each of two frames, in raster order. Output channel (out_valid/out_ready):
// exactly one result item per input item, carrying the change flag, the running
// count of changed pixels in the current frame and, on the last pixel of the
// frame (out_frame_done high), the half-open box [left,right) x [top,bottom)
// that encloses all changed pixels, or an all-zero box if nothing changed.
// out_valid rises in the cycle after acceptance. Throughput is one item per
// cycle while the receiver keeps up; the path from the input ports through the
// position compare, min/max update and box select into the result register sets
// the clock. The result register holds a finished item while the receiver
// stalls; a new item is accepted in the same cycle that the held one is taken,
// so in_ready falls only while out_valid is high and out_ready is low.
// Reset (rst_n low, synchronous) sets both size registers to 2048 and starts a
// fresh frame. A write on the cfg port (cfg_we) takes effect at once and also
// restarts the frame; a size of zero counts as one and a size above the
// maximum is clamped to MAX_WIDTH or MAX_HEIGHT.
`default_nettype none

module frame_diff_bounding_box #(
  parameter int MAX_WIDTH  = fdbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdbb_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration write port.
  input  wire logic                           cfg_we,
  input  wire logic [fdbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fdbb_pkg::CFG_W-1:0]     cfg_wdata,
  // Pixel pair items.
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [fdbb_pkg::PIX_W-1:0]     in_pixel_first,
  input  wire logic [fdbb_pkg::PIX_W-1:0]     in_pixel_second,
  // Result items.
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_pixel_changed,
  output logic                                out_frame_done,
  output logic      [fdbb_pkg::COUNT_W-1:0]   out_change_count,
  output logic      [fdbb_pkg::BOX_W-1:0]     out_box_left,
  output logic      [fdbb_pkg::BOX_W-1:0]     out_box_top,
  output logic      [fdbb_pkg::BOX_W-1:0]     out_box_right,
  output logic      [fdbb_pkg::BOX_W-1:0]     out_box_bottom
);
  import fdbb_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  // Compare widths wide enough for both the register and the limit.
  localparam int SW_W = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int SW_H = ((RW > CFG_W) ? RW : CFG_W) + 1;

  // Size registers, kept as written; the clamp is applied on the way out.
  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic [CW-1:0]    eff_width;
  logic [RW-1:0]    eff_height;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata;
        default: begin
          frame_width_nxt  = frame_width_r;
          frame_height_nxt = frame_height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_SIZE_RESET;
      frame_height_r <= CFG_SIZE_RESET;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // Effective sizes: zero reads as one, anything above the limit as the limit.
  always_comb begin
    if (frame_width_r == '0) begin
      eff_width = CW'(1);
    end else if (SW_W'(frame_width_r) > SW_W'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = CW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_height = RW'(1);
    end else if (SW_H'(frame_height_r) > SW_H'(MAX_HEIGHT)) begin
      eff_height = RW'(MAX_HEIGHT);
    end else begin
      eff_height = RW'(frame_height_r);
    end
  end

  // Handshake. The result register frees up when its item is taken, so the
  // input side keeps moving as long as the receiver does.
  logic       accept;
  fdbb_ctrl_t ctrl;

  assign in_ready     = !out_valid || out_ready;
  assign accept       = in_valid && in_ready;
  assign ctrl.step    = accept;
  assign ctrl.restart = cfg_we;

  // Raster position of the item being accepted.
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          last;

  fdbb_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .col        (col),
    .row        (row),
    .last       (last)
  );

  // A pixel changed when the two frames disagree at this position.
  logic changed;
  assign changed = in_pixel_first != in_pixel_second;

  logic [COUNT_W-1:0] count;
  logic [BOX_W-1:0]   left, top, right, bottom;

  fdbb_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .changed (changed),
    .col     (col),
    .row     (row),
    .last    (last),
    .count   (count),
    .left    (left),
    .top     (top),
    .right   (right),
    .bottom  (bottom)
  );

  // Result register.
  logic               out_valid_r;
  logic               changed_r, done_r;
  logic [COUNT_W-1:0] count_r;
  logic [BOX_W-1:0]   left_r, top_r, right_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      changed_r <= changed;
      done_r    <= last;
      count_r   <= count;
      left_r    <= left;
      top_r     <= top;
      right_r   <= right;
      bottom_r  <= bottom;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_changed = changed_r;
  assign out_frame_done    = done_r;
  assign out_change_count  = count_r;
  assign out_box_left      = left_r;
  assign out_box_top       = top_r;
  assign out_box_right     = right_r;
  assign out_box_bottom    = bottom_r;

  // A held result blocks new items until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted while result register is stalled");

  // The box is only reported on the last pixel of a frame with changes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (!out_frame_done || out_change_count == '0)) |->
      (out_box_left == '0 && out_box_top == '0 &&
       out_box_right == '0 && out_box_bottom == '0))
    else $error("nonzero box outside a frame end with changes");

  // A reported box is never empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done && out_change_count != '0) |->
      (out_box_left < out_box_right && out_box_top < out_box_bottom))
    else $error("empty bounding box reported with changes counted");

  // A changed pixel is always included in the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_changed) |-> (out_change_count != '0))
    else $error("changed pixel with zero count");

endmodule

`default_nettype wire
